FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define TCRA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcra assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define TCRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcra assertion failed");

`endif

FILE: design/tcra_pkg.sv
package tcra_pkg;

  localparam int MAX_NODES   = 32;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = 5;
  localparam int ROW_W       = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 1;

  // usable nodes: smaller of the build limit and the store size
  localparam int NODE_LIM_I = (MAX_NODES < STORE_DEPTH) ? MAX_NODES : STORE_DEPTH;
  localparam logic [CNT_W-1:0] NODE_LIM = CNT_W'(NODE_LIM_I);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REACH_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] col_addr;
    logic              edge_bit;
    logic              load_last;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row_index;
    logic [ROW_W-1:0]  reach_row;
    logic [CNT_W-1:0]  reach_count;
    logic              over_threshold;
    logic [ADDR_W-1:0] best_node;
    logic [CNT_W-1:0]  best_count;
    logic              all_reachable;
    logic              last_row;
  } out_word_t;

  // row unit operations
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MERGE = 2'd1,
    OP_COUNT = 2'd2
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [ADDR_W-1:0] k;
    logic [ADDR_W-1:0] col;
    logic              edge_bit;
  } row_ctl_t;

  // bit j set for every node j below n
  function automatic logic [ROW_W-1:0] node_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

endpackage

FILE: design/tcra_row_store.sv
module tcra_row_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [tcra_pkg::ADDR_W-1:0] wr_addr,
  input  logic [tcra_pkg::ROW_W-1:0]  wr_data,
  input  logic [tcra_pkg::ADDR_W-1:0] rd_addr,
  output logic [tcra_pkg::ROW_W-1:0]  rd_data
);
  import tcra_pkg::*;

  logic [ROW_W-1:0] mem [STORE_DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/tcra_row_unit.sv
module tcra_row_unit (
  input  tcra_pkg::row_ctl_t          ctl,
  input  logic [tcra_pkg::ROW_W-1:0]  row_in,
  input  logic [tcra_pkg::ROW_W-1:0]  row_k,
  input  logic [tcra_pkg::ROW_W-1:0]  mask,
  output logic [tcra_pkg::ROW_W-1:0]  row_out,
  output logic [tcra_pkg::CNT_W-1:0]  count
);
  import tcra_pkg::*;

  logic [ROW_W-1:0] masked;
  logic [1:0]       l1 [16];
  logic [2:0]       l2 [8];
  logic [3:0]       l3 [4];
  logic [4:0]       l4 [2];

  assign masked = row_in & mask;

  always_comb begin
    case (ctl.op)
      OP_LOAD: begin
        row_out = row_in;
        row_out[ctl.col] = ctl.edge_bit;
      end
      OP_MERGE: begin
        // row i reaches k, so it reaches all of row k
        row_out = row_in[ctl.k] ? (row_in | (row_k & mask)) : row_in;
      end
      OP_COUNT: begin
        row_out = masked;
      end
      default: begin
        row_out = row_in;
      end
    endcase
  end

  // population count tree
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      l1[j] = {1'b0, masked[2*j]} + {1'b0, masked[2*j+1]};
    end
    for (int j = 0; j < 8; j++) begin
      l2[j] = {1'b0, l1[2*j]} + {1'b0, l1[2*j+1]};
    end
    for (int j = 0; j < 4; j++) begin
      l3[j] = {1'b0, l2[2*j]} + {1'b0, l2[2*j+1]};
    end
    for (int j = 0; j < 2; j++) begin
      l4[j] = {1'b0, l3[2*j]} + {1'b0, l3[2*j+1]};
    end
  end

  assign count = {1'b0, l4[0]} + {1'b0, l4[1]};

endmodule

FILE: design/transitive_closure_reach_analyzer_core.sv
// reachability analyzer: warshall closure over a 32 x 32 bit-matrix store
//
// input channel (in_valid/in_ready/in_data): one adjacency entry per word,
// row, column and edge bit; each word is accepted, then its store row gets a
// read-modify-write. a word with load_last set starts a run.
// a run first does the closure: for each pivot a pivot row read, then one row
// read and one row write per cycle through the store's separate read and write
// ports and the shared row unit; then each result row is read, counted and handed to the output register.
// in_ready stays low for the whole run.
// output channel (out_valid/out_ready/out_data): one word per row 0..n-1,
// the last one carrying best node, best count and all-reachable.
// a stalled receiver holds the output register and the run waits on it.
// config port (cfg_we/cfg_index/cfg_data): writes take effect at once and
// are meant for idle periods only; n is sampled when a run starts.
// reset (rst_n low, synchronous): control, config and summary registers
// return to defaults; the row store is not cleared and has no clearing pass.
module transitive_closure_reach_analyzer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tcra_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tcra_pkg::out_word_t            out_data,
  input  logic                           cfg_we,
  input  logic [tcra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcra_pkg::CNT_W-1:0]     cfg_data
);
  import tcra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,  // waiting for an entry
    S_LOAD = 7'b0000010,  // store row back with the new bit
    S_KRD  = 7'b0000100,  // read pivot row k
    S_KCAP = 7'b0001000,  // latch pivot row, read row 0
    S_IUPD = 7'b0010000,  // merge row i, read row i+1
    S_ERD  = 7'b0100000,  // read result row
    S_EOUT = 7'b1000000   // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  node_count_r, node_count_nxt;
  logic [CNT_W-1:0]  reach_threshold_r, reach_threshold_nxt;

  // captured entry
  logic [ADDR_W-1:0] ld_row_r, ld_col_r;
  logic              ld_bit_r, ld_last_r, ld_ok_r;

  // run state
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [ROW_W-1:0]  mask_r, mask_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ROW_W-1:0]  rowk_r;
  logic              cnt_stage_r;  // result row data is in the count stage
  logic [ROW_W-1:0]  row_r;
  logic [CNT_W-1:0]  cnt_r;

  // summary over emitted rows
  logic [CNT_W-1:0]  best_count_r, best_count_nxt;
  logic [ADDR_W-1:0] best_node_r, best_node_nxt;
  logic              all_reach_r, all_reach_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r;

  logic [CNT_W-1:0]  n_clamp;
  logic              i_last, k_last, can_load, in_fire;
  logic [ROW_W-1:0]  need;

  // store and row unit wiring
  logic              st_wr_en;
  logic [ADDR_W-1:0] st_wr_addr, st_rd_addr;
  logic [ROW_W-1:0]  st_rd_data;
  row_ctl_t          ctl;
  logic [ROW_W-1:0]  unit_row;
  logic [CNT_W-1:0]  unit_cnt;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign can_load = !out_valid_r || out_ready;
  assign i_last   = (CNT_W'(i_r) + CNT_W'(1)) == n_r;
  assign k_last   = (CNT_W'(k_r) + CNT_W'(1)) == n_r;

  // node count 0 runs as one node, large values clip to the store limit
  always_comb begin
    if (node_count_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (node_count_r > NODE_LIM) begin
      n_clamp = NODE_LIM;
    end else begin
      n_clamp = node_count_r;
    end
  end

  // row unit controls follow the sequencer state
  always_comb begin
    ctl.k        = k_r;
    ctl.col      = ld_col_r;
    ctl.edge_bit = ld_bit_r;
    case (state_r)
      S_LOAD:  ctl.op = OP_LOAD;
      S_IUPD:  ctl.op = OP_MERGE;
      default: ctl.op = OP_COUNT;
    endcase
  end

  // store read address: entry row at accept, pivot, next row, result row
  always_comb begin
    case (state_r)
      S_IDLE:  st_rd_addr = in_data.row_addr;
      S_KRD:   st_rd_addr = k_r;
      S_KCAP:  st_rd_addr = '0;
      S_IUPD:  st_rd_addr = i_r + ADDR_W'(1);
      default: st_rd_addr = i_r;
    endcase
  end

  assign st_wr_en   = ((state_r == S_LOAD) && ld_ok_r) || (state_r == S_IUPD);
  assign st_wr_addr = (state_r == S_LOAD) ? ld_row_r : i_r;

  tcra_row_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (unit_row),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  tcra_row_unit u_unit (
    .ctl     (ctl),
    .row_in  (st_rd_data),
    .row_k   (rowk_r),
    .mask    (mask_r),
    .row_out (unit_row),
    .count   (unit_cnt)
  );

  // every node but i itself must be reached
  assign need = mask_r & ~(ROW_W'(1) << i_r);

  // config writes
  always_comb begin
    node_count_nxt      = node_count_r;
    reach_threshold_nxt = reach_threshold_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT:      node_count_nxt      = cfg_data;
        REG_REACH_THRESHOLD: reach_threshold_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    mask_nxt       = mask_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    best_count_nxt = best_count_r;
    best_node_nxt  = best_node_r;
    all_reach_nxt  = all_reach_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (ld_last_r) begin
          n_nxt          = n_clamp;
          mask_nxt       = node_mask(n_clamp);
          k_nxt          = '0;
          best_count_nxt = '0;
          best_node_nxt  = '0;
          all_reach_nxt  = 1'b1;
          state_nxt      = S_KRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_KRD: begin
        state_nxt = S_KCAP;
      end
      S_KCAP: begin
        i_nxt     = '0;
        state_nxt = S_IUPD;
      end
      S_IUPD: begin
        if (i_last) begin
          i_nxt = '0;
          if (k_last) begin
            state_nxt = S_ERD;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = S_KRD;
          end
        end else begin
          i_nxt = i_r + ADDR_W'(1);
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // first cycle here is the count stage, the word leaves afterwards
        if (!cnt_stage_r && can_load) begin
          if (cnt_r > best_count_r) begin
            best_count_nxt = cnt_r;
            best_node_nxt  = i_r;
          end
          if ((row_r & need) != need) begin
            all_reach_nxt = 1'b0;
          end
          out_valid_nxt = 1'b1;
          if (i_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + ADDR_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      node_count_r      <= CNT_W'(1);
      reach_threshold_r <= CNT_W'(2);
      best_count_r      <= '0;
      best_node_r       <= '0;
      all_reach_r       <= 1'b1;
      out_valid_r       <= 1'b0;
      cnt_stage_r       <= 1'b0;
      n_r               <= CNT_W'(1);
      k_r               <= '0;
      i_r               <= '0;
    end else begin
      state_r           <= state_nxt;
      node_count_r      <= node_count_nxt;
      reach_threshold_r <= reach_threshold_nxt;
      best_count_r      <= best_count_nxt;
      best_node_r       <= best_node_nxt;
      all_reach_r       <= all_reach_nxt;
      out_valid_r       <= out_valid_nxt;
      cnt_stage_r       <= (state_r == S_ERD);
      n_r               <= n_nxt;
      k_r               <= k_nxt;
      i_r               <= i_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (in_fire) begin
      ld_row_r  <= in_data.row_addr;
      ld_col_r  <= in_data.col_addr;
      ld_bit_r  <= in_data.edge_bit;
      ld_last_r <= in_data.load_last;
      ld_ok_r   <= (CNT_W'(in_data.row_addr) < NODE_LIM) &&
                   (CNT_W'(in_data.col_addr) < NODE_LIM);
    end
    if (state_r == S_KCAP) begin
      rowk_r <= st_rd_data;
    end
    if (cnt_stage_r) begin
      row_r <= unit_row;
      cnt_r <= unit_cnt;
    end
    if ((state_r == S_EOUT) && !cnt_stage_r && can_load) begin
      out_data_r.row_index      <= i_r;
      out_data_r.reach_row      <= row_r;
      out_data_r.reach_count    <= cnt_r;
      out_data_r.over_threshold <= (cnt_r > reach_threshold_r);
      out_data_r.best_node      <= i_last ? best_node_nxt : '0;
      out_data_r.best_count     <= i_last ? best_count_nxt : '0;
      out_data_r.all_reachable  <= i_last ? all_reach_nxt : 1'b0;
      out_data_r.last_row       <= i_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/tcra_checker.sv
`include "assert_macros.svh"

module tcra_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tcra_pkg::out_word_t out_data
);
  import tcra_pkg::*;

  // a stalled word stays offered
  `TCRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // every accepted entry is followed by a store update cycle
  `TCRA_ASSERT_NEXT(a_load_busy, in_valid && in_ready, !in_ready)

  // count field matches the row bits
  `TCRA_ASSERT_SAME(a_count_match, out_valid,
    out_data.reach_count == CNT_W'($countones(out_data.reach_row)))

  // summary fields only on the final row
  `TCRA_ASSERT_SAME(a_summary_last, out_valid && !out_data.last_row,
    out_data.best_node == '0 && out_data.best_count == '0 && !out_data.all_reachable)

endmodule

bind transitive_closure_reach_analyzer_core tcra_port_checker u_tcra_checker (.*);
